// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file cite_checker.sv.
// Each macro wraps one clocked implication with an asynchronous reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CITE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cite assertion failed");

// next-cycle implication
`define CITE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cite assertion failed");

`endif

// ----- src/cite_pkg.sv -----
// Types, character codes and mnemonic tables of the C-instruction text encoder.
// Used by cite_decode and c_instruction_text_encoder.
package cite_pkg;

	localparam logic [7:0] EQ_CHAR   = 8'h3D;
	localparam logic [7:0] SEMI_CHAR = 8'h3B;
	localparam logic [7:0] A_CHAR    = 8'h41;
	localparam logic [7:0] D_CHAR    = 8'h44;
	localparam logic [7:0] M_CHAR    = 8'h4D;

	localparam logic [2:0] WORD_PREFIX = 3'b111;
	localparam logic [2:0] TOKEN_MAX   = 3'd3;
	localparam int         COMP_COUNT  = 28;
	localparam int         JUMP_COUNT  = 7;

	localparam logic [2:0] DEST_A = 3'b100;
	localparam logic [2:0] DEST_D = 3'b010;
	localparam logic [2:0] DEST_M = 3'b001;

	typedef struct packed {
		logic [2:0]        len;
		logic [0:2][7:0]   chars;
	} token_t;

	typedef struct packed {
		logic [2:0]        len;
		logic [0:2][7:0]   chars;
		logic [6:0]        code;
	} mnemonic_t;

	typedef struct packed {
		logic       comp_hit;
		logic [6:0] comp_code;
		logic [2:0] jump_code;
	} decode_t;

	localparam mnemonic_t COMP_TABLE [COMP_COUNT] = '{
		'{3'd1, {"0", 16'h0000}, 7'h2A}, '{3'd1, {"1", 16'h0000}, 7'h3F},
		'{3'd2, {"-", "1", 8'h00}, 7'h3A}, '{3'd1, {"D", 16'h0000}, 7'h0C},
		'{3'd1, {"A", 16'h0000}, 7'h30}, '{3'd2, {"!", "D", 8'h00}, 7'h0D},
		'{3'd2, {"!", "A", 8'h00}, 7'h31}, '{3'd2, {"-", "D", 8'h00}, 7'h0F},
		'{3'd2, {"-", "A", 8'h00}, 7'h33}, '{3'd3, "D+1", 7'h1F},
		'{3'd3, "A+1", 7'h37}, '{3'd3, "D-1", 7'h0E},
		'{3'd3, "A-1", 7'h32}, '{3'd3, "D+A", 7'h02},
		'{3'd3, "D-A", 7'h13}, '{3'd3, "A-D", 7'h07},
		'{3'd3, "D&A", 7'h00}, '{3'd3, "D|A", 7'h15},
		'{3'd1, {"M", 16'h0000}, 7'h70}, '{3'd2, {"!", "M", 8'h00}, 7'h71},
		'{3'd2, {"-", "M", 8'h00}, 7'h73}, '{3'd3, "M+1", 7'h77},
		'{3'd3, "M-1", 7'h72}, '{3'd3, "D+M", 7'h42},
		'{3'd3, "D-M", 7'h53}, '{3'd3, "M-D", 7'h47},
		'{3'd3, "D&M", 7'h40}, '{3'd3, "D|M", 7'h55}
	};

	localparam mnemonic_t JUMP_TABLE [JUMP_COUNT] = '{
		'{3'd3, "JGT", 7'd1}, '{3'd3, "JEQ", 7'd2}, '{3'd3, "JGE", 7'd3},
		'{3'd3, "JLT", 7'd4}, '{3'd3, "JNE", 7'd5}, '{3'd3, "JLE", 7'd6},
		'{3'd3, "JMP", 7'd7}
	};

	// unused token positions are always zero, as are unused table positions
	function automatic logic tok_match(input token_t t, input mnemonic_t m);
		return (t.len == m.len) && (t.chars == m.chars);
	endfunction

endpackage

// ----- src/cite_if.sv -----
// Handshake channels of the encoder: character stream in, instruction words out.
// No dependencies.
interface cite_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;

	modport source(output valid, char_code, last, input ready);
	modport sink(input valid, char_code, last, output ready);
endinterface

interface cite_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] instruction_word;
	logic        comp_error;

	modport source(output valid, instruction_word, comp_error, input ready);
	modport sink(input valid, instruction_word, comp_error, output ready);
endinterface

// ----- src/c_instruction_text_encoder.sv -----
// Top level of the C-instruction text encoder: input register, parse state,
// result register. Depends on cite_pkg, cite_if and cite_decode.
//
//   channel  dir  payload                         transfer
//   text     in   char_code[7:0], last            one character
//   word     out  instruction_word[15:0], comp_error  one word per last char
//
// One character per cycle, back to back. A word is valid at the ports once its
// last character has passed from the input register into the result register.
// Input stalls only when a last character sits in the input register while the
// result register still holds an untaken word.
// Reset clears the parse state and both valid flags; no clearing pass.
module c_instruction_text_encoder
	import cite_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	cite_text_if.sink   text,
	cite_word_if.source word
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	logic [2:0] dest_q;
	logic       seen_eq_q;
	logic       seen_semi_q;
	token_t     tok_q;
	logic [6:0] comp_q;
	logic       bad_q;

	logic        out_valid_q;
	logic [15:0] word_q;
	logic        err_q;

	logic       out_free;
	logic       advance;
	logic       fire;
	logic       is_eq;
	logic       is_semi;
	logic [2:0] dest_n;
	logic       seen_eq_n;
	logic       seen_semi_n;
	token_t     tok_n;
	logic [6:0] comp_n;
	logic       bad_n;
	token_t     comp_tok;
	decode_t    dec;
	logic [6:0] comp_fin;
	logic       bad_fin;
	logic [2:0] jump_fin;
	logic [15:0] word_n;

	assign out_free   = !out_valid_q || word.ready;
	assign advance    = !last_s1 || out_free;
	assign fire       = valid_s1 && advance;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			char_s1 <= text.char_code;
			last_s1 <= text.last;
		end
	end

	assign is_eq   = (char_s1 == EQ_CHAR) && !seen_eq_q && !seen_semi_q;
	assign is_semi = !is_eq && (char_s1 == SEMI_CHAR) && !seen_semi_q;

	always_comb begin
		dest_n      = dest_q;
		seen_eq_n   = seen_eq_q;
		seen_semi_n = seen_semi_q;
		tok_n       = tok_q;
		comp_n      = comp_q;
		bad_n       = bad_q;
		if (is_eq) begin
			seen_eq_n = 1'b1;
			tok_n     = '0;
		end else if (is_semi) begin
			comp_n      = dec.comp_hit ? dec.comp_code : 7'd0;
			bad_n       = !dec.comp_hit;
			seen_semi_n = 1'b1;
			tok_n       = '0;
		end else begin
			if (!seen_eq_q && !seen_semi_q) begin
				if (char_s1 == A_CHAR) dest_n = dest_q | DEST_A;
				else if (char_s1 == D_CHAR) dest_n = dest_q | DEST_D;
				else if (char_s1 == M_CHAR) dest_n = dest_q | DEST_M;
			end
			if (tok_q.len < TOKEN_MAX) begin
				tok_n.chars[tok_q.len[1:0]] = char_s1;
			end
			if (tok_q.len <= TOKEN_MAX) begin
				tok_n.len = tok_q.len + 3'd1;
			end
		end
	end

	assign comp_tok = is_semi ? tok_q : tok_n;

	cite_decode u_decode (
		.comp_tok (comp_tok),
		.jump_tok (tok_n),
		.dec      (dec)
	);

	always_comb begin
		if (seen_semi_n) begin
			comp_fin = comp_n;
			bad_fin  = bad_n;
			jump_fin = dec.jump_code;
		end else begin
			comp_fin = dec.comp_hit ? dec.comp_code : 7'd0;
			bad_fin  = !dec.comp_hit;
			jump_fin = 3'd0;
		end
		word_n = {WORD_PREFIX, comp_fin, seen_eq_n ? dest_n : 3'd0, jump_fin};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q      <= '0;
			seen_eq_q   <= 1'b0;
			seen_semi_q <= 1'b0;
			tok_q       <= '0;
			comp_q      <= '0;
			bad_q       <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				dest_q      <= '0;
				seen_eq_q   <= 1'b0;
				seen_semi_q <= 1'b0;
				tok_q       <= '0;
				comp_q      <= '0;
				bad_q       <= 1'b0;
			end else begin
				dest_q      <= dest_n;
				seen_eq_q   <= seen_eq_n;
				seen_semi_q <= seen_semi_n;
				tok_q       <= tok_n;
				comp_q      <= comp_n;
				bad_q       <= bad_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (word.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			word_q <= word_n;
			err_q  <= bad_fin;
		end
	end

	assign word.valid            = out_valid_q;
	assign word.instruction_word = word_q;
	assign word.comp_error       = err_q;

endmodule

// ----- src/cite_decode.sv -----
// Token matcher: compares the comp token against the comp mnemonics and the
// jump token against the jump mnemonics. Depends on cite_pkg.
module cite_decode
	import cite_pkg::*;
(
	input  token_t  comp_tok,
	input  token_t  jump_tok,
	output decode_t dec
);

	logic [COMP_COUNT-1:0] comp_hits;
	logic [JUMP_COUNT-1:0] jump_hits;

	always_comb begin
		for (int i = 0; i < COMP_COUNT; i++) begin
			comp_hits[i] = tok_match(comp_tok, COMP_TABLE[i]);
		end
		for (int j = 0; j < JUMP_COUNT; j++) begin
			jump_hits[j] = tok_match(jump_tok, JUMP_TABLE[j]);
		end
	end

	// mnemonics are distinct, so at most one hit per table
	always_comb begin
		dec.comp_hit  = |comp_hits;
		dec.comp_code = '0;
		dec.jump_code = '0;
		for (int i = 0; i < COMP_COUNT; i++) begin
			if (comp_hits[i]) begin
				dec.comp_code = dec.comp_code | COMP_TABLE[i].code;
			end
		end
		for (int j = 0; j < JUMP_COUNT; j++) begin
			if (jump_hits[j]) begin
				dec.jump_code = dec.jump_code | JUMP_TABLE[j].code[2:0];
			end
		end
	end

endmodule

// ----- src/cite_checker.sv -----
// Port-level checks of the C-instruction text encoder, bound to the top level.
// Depends on assert_macros.svh and cite_if.
`include "assert_macros.svh"

module cite_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_word,
	input logic        out_err
);

	`CITE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(out_err))
	`CITE_ASSERT_NOW(a_prefix, clk, arst_n, out_valid, out_word[15:13] == 3'b111)
	`CITE_ASSERT_NOW(a_err_zero_comp, clk, arst_n, out_valid && out_err, out_word[12:6] == 7'd0)
	`CITE_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !in_valid || out_valid)

endmodule

bind c_instruction_text_encoder cite_checker u_cite_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text.valid),
	.in_ready  (text.ready),
	.out_valid (word.valid),
	.out_ready (word.ready),
	.out_word  (word.instruction_word),
	.out_err   (word.comp_error)
);
